[rtl/assert_macros.svh]
// Assertion macros shared by the DDS table player RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define DCDDS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DCDDS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define DCDDS_ASSERT(lbl, clk, rst_n, prop, msg)
`define DCDDS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

[rtl/dcdds_pkg.sv]
// Shared constants and types for the dual channel DDS table player.
package dcdds_pkg;

	localparam int TABLE_DEPTH_DEF = 2048;
	localparam int INDEX_SHIFT_DEF = 20;

	localparam int ACC_W       = 32;
	localparam int WORD_W      = 16;
	localparam int ENTRY_IDX_W = 11;
	localparam int PERIOD_W    = 31;
	localparam int CMD_W       = 3;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE_A = 3'd1;
	localparam logic [CMD_W-1:0] CMD_WRITE_B = 3'd2;
	localparam logic [CMD_W-1:0] CMD_START   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_STOP    = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP_B = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ENABLE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_COUNT = 2'd3;

	// Tick issued to the table read stage.
	typedef struct packed {
		logic fire;
		logic halted;
	} tick_t;

endpackage

[rtl/dcdds_wave_mem.sv]
// One wave table: single write port, single registered read port.
module dcdds_wave_mem #(
	parameter int DEPTH = dcdds_pkg::TABLE_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [dcdds_pkg::WORD_W-1:0]  wdata,
	input  logic                          re,
	input  logic [AW-1:0]                 raddr,
	output logic [dcdds_pkg::WORD_W-1:0]  rdata
);

	logic [dcdds_pkg::WORD_W-1:0] mem [DEPTH];
	logic [dcdds_pkg::WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while no read is issued, so it doubles as the output stage
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/dcdds_phase.sv]
// Config registers, phase accumulators, period counter and run control.
module dcdds_phase #(
	parameter int TABLE_DEPTH = dcdds_pkg::TABLE_DEPTH_DEF,
	parameter int INDEX_SHIFT = dcdds_pkg::INDEX_SHIFT_DEF,
	parameter int AW          = $clog2(TABLE_DEPTH)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dcdds_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dcdds_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                              in_fire,
	input  logic [dcdds_pkg::CMD_W-1:0]       cmd,
	output logic [AW-1:0]                     addr_a,
	output logic [AW-1:0]                     addr_b,
	output dcdds_pkg::tick_t                  tick
);

	localparam logic [dcdds_pkg::ACC_W-1:0] DEPTH_V = dcdds_pkg::ACC_W'(TABLE_DEPTH);

	logic [dcdds_pkg::ACC_W-1:0]    step_a_q, step_b_q;
	logic                           limit_q;
	logic [dcdds_pkg::PERIOD_W-1:0] period_q;

	logic [dcdds_pkg::ACC_W-1:0] acc_a_q, acc_b_q, periods_q;
	logic                        running_q;

	logic [dcdds_pkg::ACC_W-1:0] sum_a, sum_b, idx_a, idx_b;
	logic [dcdds_pkg::ACC_W-1:0] acc_a_d, acc_b_d, periods_d;
	logic                        wrap_a, wrap_b, halt;

	always_comb begin
		sum_a     = acc_a_q + step_a_q;
		sum_b     = acc_b_q + step_b_q;
		idx_a     = sum_a >> INDEX_SHIFT;
		idx_b     = sum_b >> INDEX_SHIFT;
		wrap_a    = idx_a >= DEPTH_V;
		wrap_b    = idx_b >= DEPTH_V;
		acc_a_d   = wrap_a ? '0 : sum_a;
		acc_b_d   = wrap_b ? '0 : sum_b;
		addr_a    = wrap_a ? '0 : idx_a[AW-1:0];
		addr_b    = wrap_b ? '0 : idx_b[AW-1:0];
		// both channels may wrap on the same tick; counter wraps below zero
		periods_d = periods_q - {31'b0, wrap_a} - {31'b0, wrap_b};
		halt      = limit_q && (periods_d == '0);
	end

	assign tick.fire   = in_fire && (cmd == dcdds_pkg::CMD_TICK) && running_q;
	assign tick.halted = halt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_a_q <= '0;
			step_b_q <= '0;
			limit_q  <= 1'b0;
			period_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				dcdds_pkg::REG_PHASE_STEP_A: step_a_q <= cfg_data;
				dcdds_pkg::REG_PHASE_STEP_B: step_b_q <= cfg_data;
				dcdds_pkg::REG_LIMIT_ENABLE: limit_q  <= cfg_data[0];
				dcdds_pkg::REG_PERIOD_COUNT: period_q <= cfg_data[dcdds_pkg::PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_a_q   <= '0;
			acc_b_q   <= '0;
			periods_q <= '0;
			running_q <= 1'b0;
		end else if (in_fire) begin
			case (cmd)
				dcdds_pkg::CMD_TICK: begin
					if (running_q) begin
						acc_a_q   <= acc_a_d;
						acc_b_q   <= acc_b_d;
						periods_q <= periods_d;
						running_q <= !halt;
					end
				end
				dcdds_pkg::CMD_START: begin
					running_q <= 1'b1;
					periods_q <= {period_q, 1'b0};
				end
				dcdds_pkg::CMD_STOP: begin
					running_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

endmodule

[rtl/dual_channel_dds_table_player.sv]
// Dual channel DDS table player: phase control feeding two wave table memories.
//
// Usage:
//   Configuration writes (cfg_we, cfg_index, cfg_data) set the two phase steps,
//   limit enable and period count; write only while the block is idle.
//   Input beats carry a command: tick, write table A/B, start or stop.
//   Only a tick taken while running returns an output beat, with the two
//   table words and a halted flag that marks the tick ending a limited run.
//   Latency: a tick's output beat is valid the cycle after the input beat.
//   Throughput: one input beat per cycle; the accumulate, wrap compare and
//   table read address are all combinational, and the synchronous table
//   read register serves as the output stage.
//   When out_ready is low with an output beat pending, in_ready drops and
//   the beat and the read data hold until taken.
//   Reset clears accumulators, counter, run state and config registers;
//   table contents are not cleared and must be written before they are read.
module dual_channel_dds_table_player #(
	parameter int TABLE_DEPTH = dcdds_pkg::TABLE_DEPTH_DEF,
	parameter int INDEX_SHIFT = dcdds_pkg::INDEX_SHIFT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dcdds_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dcdds_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [dcdds_pkg::CMD_W-1:0]         cmd,
	input  logic [dcdds_pkg::ENTRY_IDX_W-1:0]   entry_index,
	input  logic [dcdds_pkg::WORD_W-1:0]        entry_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [dcdds_pkg::WORD_W-1:0]        word_a,
	output logic [dcdds_pkg::WORD_W-1:0]        word_b,
	output logic                                halted
);

	`include "assert_macros.svh"

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic [31:0] DEPTH_V = 32'(TABLE_DEPTH);

	logic             in_fire;
	logic [AW-1:0]    addr_a, addr_b, waddr;
	logic [31:0]      eidx_ext;
	logic             eidx_ok, we_a, we_b;
	dcdds_pkg::tick_t tick;
	logic             valid_s1, halted_s1;

	assign in_ready = !valid_s1 || out_ready;
	assign in_fire  = in_valid && in_ready;

	assign eidx_ext = 32'(entry_index);
	assign eidx_ok  = eidx_ext < DEPTH_V;
	assign waddr    = eidx_ext[AW-1:0];
	assign we_a     = in_fire && (cmd == dcdds_pkg::CMD_WRITE_A) && eidx_ok;
	assign we_b     = in_fire && (cmd == dcdds_pkg::CMD_WRITE_B) && eidx_ok;

	dcdds_phase #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.INDEX_SHIFT (INDEX_SHIFT),
		.AW          (AW)
	) u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_fire   (in_fire),
		.cmd       (cmd),
		.addr_a    (addr_a),
		.addr_b    (addr_b),
		.tick      (tick)
	);

	dcdds_wave_mem #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_mem_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (entry_value),
		.re    (tick.fire),
		.raddr (addr_a),
		.rdata (word_a)
	);

	dcdds_wave_mem #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_mem_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (entry_value),
		.re    (tick.fire),
		.raddr (addr_b),
		.rdata (word_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= tick.fire;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.fire) begin
			halted_s1 <= tick.halted;
		end
	end

	assign out_valid = valid_s1;
	assign halted    = halted_s1;

	`DCDDS_ASSERT(a_no_beat_without_tick, clk, arst_n, (in_fire && !tick.fire) |=> !valid_s1, "output beat without a running tick")
	`DCDDS_ASSERT(a_halt_reaches_output, clk, arst_n, (tick.fire && tick.halted) |=> (valid_s1 && halted_s1), "halting tick lost its flag")
	`DCDDS_ASSERT_NEVER(a_no_rw_overlap, clk, arst_n, (we_a || we_b) && tick.fire, "table write and read in the same cycle")

endmodule
